// ===== src/assert_macros.svh =====
// assertion macros used by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define HRHP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HRHP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/hrhp_pkg.sv =====
// types, codes and lookup functions for the response header parser
`timescale 1ns / 1ps

package hrhp_pkg;

   localparam int NAME_MAX_LEN_DEF     = 20;
   localparam int VALUE_MAX_LEN_DEF    = 1024;
   localparam int LOCATION_MAX_LEN_DEF = 256;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam logic [9:0] STATUS_OK        = 10'd200;
   localparam logic [9:0] STATUS_MOVED     = 10'd301;
   localparam logic [9:0] STATUS_FOUND     = 10'd302;
   localparam logic [9:0] STATUS_SEE_OTHER = 10'd303;
   localparam logic [9:0] STATUS_TEMP      = 10'd307;

   localparam int LEN_NAME_LEN = 14;
   localparam int LOC_NAME_LEN = 8;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_EOS   = 2'd1,
      OP_START = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      OUTCOME_PENDING  = 2'd0,
      OUTCOME_OK       = 2'd1,
      OUTCOME_REDIRECT = 2'd2,
      OUTCOME_FAILED   = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_LEN  = 2'd1,
      KIND_LOC  = 2'd2
   } kind_type;

   typedef enum logic [10:0] {
      PH_VERSION    = 11'b000_0000_0001,
      PH_STATUS     = 11'b000_0000_0010,
      PH_SKIPLINE   = 11'b000_0000_0100,
      PH_FIELDFIRST = 11'b000_0000_1000,
      PH_NAME       = 11'b000_0001_0000,
      PH_VALUE      = 11'b000_0010_0000,
      PH_SKIPNAME   = 11'b000_0100_0000,
      PH_SKIPVALUE  = 11'b000_1000_0000,
      PH_DONE_OK    = 11'b001_0000_0000,
      PH_DONE_REDIR = 11'b010_0000_0000,
      PH_DONE_FAIL  = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic        header_done;
      outcome_type outcome;
      logic [9:0]  status_code;
      logic [31:0] content_length;
      logic        content_length_known;
      logic [23:0] header_bytes;
      logic [7:0]  location_byte;
      logic        location_byte_valid;
      logic        location_restart;
   } result_type;

   function automatic logic [7:0] lower_of(input logic [7:0] c);
      if (c inside {[8'h41:8'h5A]}) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0B, 8'h0C};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_token_byte(input logic [7:0] c);
      if (c < 8'h20) begin
         return 1'b0;
      end
      return !(c inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
                         "[", "]", "?", "=", "{", "}", " "});
   endfunction

   // "content-length", one character per position
   function automatic logic [7:0] len_name_char(input logic [5:0] pos);
      logic [7:0] ch;
      case (pos)
         6'd0:    ch = "c";
         6'd1:    ch = "o";
         6'd2:    ch = "n";
         6'd3:    ch = "t";
         6'd4:    ch = "e";
         6'd5:    ch = "n";
         6'd6:    ch = "t";
         6'd7:    ch = "-";
         6'd8:    ch = "l";
         6'd9:    ch = "e";
         6'd10:   ch = "n";
         6'd11:   ch = "g";
         6'd12:   ch = "t";
         6'd13:   ch = "h";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // "location", one character per position
   function automatic logic [7:0] loc_name_char(input logic [5:0] pos);
      logic [7:0] ch;
      case (pos)
         6'd0:    ch = "l";
         6'd1:    ch = "o";
         6'd2:    ch = "c";
         6'd3:    ch = "a";
         6'd4:    ch = "t";
         6'd5:    ch = "i";
         6'd6:    ch = "o";
         6'd7:    ch = "n";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // bit 0: still matches content-length, bit 1: still matches location
   function automatic logic [1:0] match_at(input logic [5:0] pos, input logic [7:0] c);
      logic [7:0] l;
      logic [1:0] m;
      l = lower_of(c);
      m = 2'b00;
      if (pos < 6'(LEN_NAME_LEN) && l == len_name_char(pos)) begin
         m[0] = 1'b1;
      end
      if (pos < 6'(LOC_NAME_LEN) && l == loc_name_char(pos)) begin
         m[1] = 1'b1;
      end
      return m;
   endfunction

endpackage

// ===== src/hrhp_core.sv =====
// parser state registers and per-item next-state logic
`timescale 1ns / 1ps

module hrhp_core #(
   parameter int NAME_MAX_LEN     = hrhp_pkg::NAME_MAX_LEN_DEF,
   parameter int VALUE_MAX_LEN    = hrhp_pkg::VALUE_MAX_LEN_DEF,
   parameter int LOCATION_MAX_LEN = hrhp_pkg::LOCATION_MAX_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           op,
   input  logic [7:0]           byte_in,
   output hrhp_pkg::result_type result
);

   localparam int NAME_W  = $clog2(NAME_MAX_LEN);
   localparam int VALUE_W = $clog2(VALUE_MAX_LEN);
   localparam int LOC_W   = $clog2(LOCATION_MAX_LEN);

   hrhp_pkg::phase_type     phase_ff, phase_in;
   logic [9:0]              status_ff, status_in;
   logic [1:0]              digit_count_ff, digit_count_in;
   logic [NAME_W-1:0]       name_length_ff, name_length_in;
   logic [1:0]              name_match_ff, name_match_in;
   hrhp_pkg::kind_type      kind_ff, kind_in;
   logic                    value_started_ff, value_started_in;
   logic [VALUE_W-1:0]      value_length_ff, value_length_in;
   logic [31:0]             accum_ff, accum_in;
   logic                    accum_ok_ff, accum_ok_in;
   logic [31:0]             length_value_ff, length_value_in;
   logic                    length_known_ff, length_known_in;
   logic [LOC_W-1:0]        loc_count_ff, loc_count_in;
   logic [23:0]             byte_count_ff, byte_count_in;

   logic        finished, finished_next;
   logic        do_value, do_commit, do_end;
   logic        emit_valid, emit_restart;
   logic [7:0]  emit_byte;
   logic [7:0]  c;
   logic [3:0]  digit;
   logic [13:0] status_prod;
   logic [35:0] accum_prod;
   logic        redirect_code;

   assign c           = byte_in;
   assign digit       = c[3:0];
   assign status_prod = ({4'b0, status_ff} << 3) + ({4'b0, status_ff} << 1) + {10'b0, digit};
   assign accum_prod  = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + {32'b0, digit};

   assign redirect_code = status_ff == hrhp_pkg::STATUS_MOVED
                       || status_ff == hrhp_pkg::STATUS_FOUND
                       || status_ff == hrhp_pkg::STATUS_SEE_OTHER
                       || status_ff == hrhp_pkg::STATUS_TEMP;

   assign finished = phase_ff inside {hrhp_pkg::PH_DONE_OK, hrhp_pkg::PH_DONE_REDIR,
                                      hrhp_pkg::PH_DONE_FAIL};
   assign finished_next = phase_in inside {hrhp_pkg::PH_DONE_OK, hrhp_pkg::PH_DONE_REDIR,
                                           hrhp_pkg::PH_DONE_FAIL};

   always_comb begin
      phase_in         = phase_ff;
      status_in        = status_ff;
      digit_count_in   = digit_count_ff;
      name_length_in   = name_length_ff;
      name_match_in    = name_match_ff;
      kind_in          = kind_ff;
      value_started_in = value_started_ff;
      value_length_in  = value_length_ff;
      accum_in         = accum_ff;
      accum_ok_in      = accum_ok_ff;
      length_value_in  = length_value_ff;
      length_known_in  = length_known_ff;
      loc_count_in     = loc_count_ff;
      byte_count_in    = byte_count_ff;
      emit_valid       = 1'b0;
      emit_byte        = 8'h00;
      emit_restart     = 1'b0;
      do_value         = 1'b0;
      do_commit        = 1'b0;
      do_end           = 1'b0;

      if (op == hrhp_pkg::OP_START) begin
         phase_in         = hrhp_pkg::PH_VERSION;
         status_in        = '0;
         digit_count_in   = '0;
         name_length_in   = '0;
         name_match_in    = '0;
         kind_in          = hrhp_pkg::KIND_NONE;
         value_started_in = 1'b0;
         value_length_in  = '0;
         accum_in         = '0;
         accum_ok_in      = 1'b1;
         length_value_in  = '1;
         length_known_in  = 1'b0;
         loc_count_in     = '0;
         byte_count_in    = '0;
      end else if (!finished) begin
         if (op == hrhp_pkg::OP_BYTE) begin
            if (byte_count_ff != '1) begin
               byte_count_in = byte_count_ff + 24'd1;
            end
            // carriage returns and nul bytes only count
            if (c != hrhp_pkg::CHAR_CR && c != hrhp_pkg::CHAR_NUL) begin
               case (phase_ff)
                  hrhp_pkg::PH_VERSION: begin
                     if (c == hrhp_pkg::CHAR_SPACE) begin
                        phase_in       = hrhp_pkg::PH_STATUS;
                        digit_count_in = '0;
                     end
                  end
                  hrhp_pkg::PH_STATUS: begin
                     if (!hrhp_pkg::is_digit(c)) begin
                        phase_in = hrhp_pkg::PH_DONE_FAIL;
                     end else begin
                        status_in      = status_prod[9:0];
                        digit_count_in = digit_count_ff + 2'd1;
                        if (digit_count_ff == 2'd2) begin
                           phase_in = hrhp_pkg::PH_SKIPLINE;
                        end
                     end
                  end
                  hrhp_pkg::PH_SKIPLINE: begin
                     if (c == hrhp_pkg::CHAR_LF) begin
                        phase_in = hrhp_pkg::PH_FIELDFIRST;
                     end
                  end
                  hrhp_pkg::PH_FIELDFIRST: begin
                     if (c == hrhp_pkg::CHAR_LF) begin
                        do_end = 1'b1;
                     end else if (hrhp_pkg::is_ws(c)) begin
                        // continuation line extends the current value
                        phase_in = hrhp_pkg::PH_VALUE;
                        do_value = 1'b1;
                     end else if (hrhp_pkg::is_token_byte(c)) begin
                        do_commit        = 1'b1;
                        name_length_in   = NAME_W'(1);
                        name_match_in    = hrhp_pkg::match_at(6'd0, c);
                        value_length_in  = '0;
                        value_started_in = 1'b0;
                        phase_in         = hrhp_pkg::PH_NAME;
                     end else begin
                        phase_in = hrhp_pkg::PH_SKIPLINE;
                     end
                  end
                  hrhp_pkg::PH_NAME: begin
                     if (c == hrhp_pkg::CHAR_COLON) begin
                        if (name_match_ff[0]
                            && name_length_ff == NAME_W'(hrhp_pkg::LEN_NAME_LEN)) begin
                           kind_in = hrhp_pkg::KIND_LEN;
                        end else if (name_match_ff[1]
                            && name_length_ff == NAME_W'(hrhp_pkg::LOC_NAME_LEN)) begin
                           kind_in = hrhp_pkg::KIND_LOC;
                        end else begin
                           kind_in = hrhp_pkg::KIND_NONE;
                        end
                        value_length_in  = '0;
                        value_started_in = 1'b0;
                        accum_in         = '0;
                        accum_ok_in      = 1'b1;
                        if (kind_in == hrhp_pkg::KIND_LOC) begin
                           loc_count_in = '0;
                           emit_restart = 1'b1;
                        end
                        phase_in = hrhp_pkg::PH_VALUE;
                     end else if (hrhp_pkg::is_token_byte(c)) begin
                        if (name_length_ff >= NAME_W'(NAME_MAX_LEN - 1)) begin
                           phase_in = hrhp_pkg::PH_SKIPNAME;
                        end else begin
                           name_match_in  = name_match_ff
                                          & hrhp_pkg::match_at(6'(name_length_ff), c);
                           name_length_in = name_length_ff + NAME_W'(1);
                        end
                     end else if (c == hrhp_pkg::CHAR_LF) begin
                        phase_in = hrhp_pkg::PH_FIELDFIRST;
                     end else begin
                        phase_in = hrhp_pkg::PH_SKIPLINE;
                     end
                  end
                  hrhp_pkg::PH_VALUE: begin
                     if (c == hrhp_pkg::CHAR_LF) begin
                        phase_in = hrhp_pkg::PH_FIELDFIRST;
                     end else begin
                        do_value = 1'b1;
                     end
                  end
                  hrhp_pkg::PH_SKIPNAME: begin
                     if (c == hrhp_pkg::CHAR_COLON) begin
                        phase_in = hrhp_pkg::PH_SKIPVALUE;
                     end else if (hrhp_pkg::is_token_byte(c)) begin
                        phase_in = hrhp_pkg::PH_SKIPNAME;
                     end else if (c == hrhp_pkg::CHAR_LF) begin
                        phase_in = hrhp_pkg::PH_FIELDFIRST;
                     end else begin
                        phase_in = hrhp_pkg::PH_SKIPLINE;
                     end
                  end
                  hrhp_pkg::PH_SKIPVALUE: begin
                     if (c == hrhp_pkg::CHAR_LF) begin
                        phase_in = hrhp_pkg::PH_FIELDFIRST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end else if (op == hrhp_pkg::OP_EOS) begin
            phase_in = hrhp_pkg::PH_DONE_FAIL;
         end
      end

      // one value byte of the current field
      if (do_value) begin
         if (value_length_ff >= VALUE_W'(VALUE_MAX_LEN - 1)) begin
            phase_in = hrhp_pkg::PH_SKIPVALUE;
         end else begin
            value_length_in = value_length_ff + VALUE_W'(1);
            if (kind_ff != hrhp_pkg::KIND_NONE
                && !(!value_started_ff && hrhp_pkg::is_ws(c))) begin
               value_started_in = 1'b1;
               if (kind_ff == hrhp_pkg::KIND_LEN) begin
                  if (accum_ok_ff) begin
                     if (hrhp_pkg::is_digit(c) && accum_prod[35:32] == 4'd0) begin
                        accum_in = accum_prod[31:0];
                     end else begin
                        accum_ok_in = 1'b0;
                     end
                  end
               end else if (kind_ff == hrhp_pkg::KIND_LOC) begin
                  if (loc_count_ff < LOC_W'(LOCATION_MAX_LEN - 1)) begin
                     loc_count_in = loc_count_ff + LOC_W'(1);
                     emit_valid   = 1'b1;
                     emit_byte    = c;
                  end
               end
            end
         end
      end

      // field commit on a new name or on the blank line
      if (do_commit || do_end) begin
         if (kind_ff == hrhp_pkg::KIND_LEN) begin
            length_value_in = accum_ok_ff ? accum_ff : '1;
            length_known_in = accum_ok_ff;
         end
         kind_in = hrhp_pkg::KIND_NONE;
      end

      if (do_end) begin
         if (status_ff == hrhp_pkg::STATUS_OK) begin
            phase_in = hrhp_pkg::PH_DONE_OK;
         end else if (redirect_code && loc_count_ff != '0) begin
            phase_in = hrhp_pkg::PH_DONE_REDIR;
         end else begin
            phase_in = hrhp_pkg::PH_DONE_FAIL;
         end
      end
   end

   always_comb begin
      result.header_done = op != hrhp_pkg::OP_START && !finished && finished_next;
      if (!finished_next) begin
         result.outcome = hrhp_pkg::OUTCOME_PENDING;
      end else if (phase_in == hrhp_pkg::PH_DONE_OK) begin
         result.outcome = hrhp_pkg::OUTCOME_OK;
      end else if (phase_in == hrhp_pkg::PH_DONE_REDIR) begin
         result.outcome = hrhp_pkg::OUTCOME_REDIRECT;
      end else begin
         result.outcome = hrhp_pkg::OUTCOME_FAILED;
      end
      result.status_code          = status_in;
      result.content_length       = length_value_in;
      result.content_length_known = length_known_in;
      result.header_bytes         = byte_count_in;
      result.location_byte        = emit_byte;
      result.location_byte_valid  = emit_valid;
      result.location_restart     = emit_restart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= hrhp_pkg::PH_VERSION;
         status_ff        <= '0;
         digit_count_ff   <= '0;
         name_length_ff   <= '0;
         name_match_ff    <= '0;
         kind_ff          <= hrhp_pkg::KIND_NONE;
         value_started_ff <= 1'b0;
         value_length_ff  <= '0;
         accum_ff         <= '0;
         accum_ok_ff      <= 1'b1;
         length_value_ff  <= '1;
         length_known_ff  <= 1'b0;
         loc_count_ff     <= '0;
         byte_count_ff    <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         status_ff        <= status_in;
         digit_count_ff   <= digit_count_in;
         name_length_ff   <= name_length_in;
         name_match_ff    <= name_match_in;
         kind_ff          <= kind_in;
         value_started_ff <= value_started_in;
         value_length_ff  <= value_length_in;
         accum_ff         <= accum_in;
         accum_ok_ff      <= accum_ok_in;
         length_value_ff  <= length_value_in;
         length_known_ff  <= length_known_in;
         loc_count_ff     <= loc_count_in;
         byte_count_ff    <= byte_count_in;
      end
   end

endmodule

// ===== src/http_response_header_parser_unit.sv =====
// an accepted item is held in the input register, then its result is registered when that slot frees up
// throughput: one item per cycle while output is drained, as the core state steps with each item that moves on
// the input register and result register both take a new item while output is drained
// reset (synchronous, active high) empties both registers and returns the parser
// to awaiting the version space, with no content length known
`timescale 1ns / 1ps

`include "assert_macros.svh"

module http_response_header_parser_unit #(
   parameter int NAME_MAX_LEN     = hrhp_pkg::NAME_MAX_LEN_DEF,
   parameter int VALUE_MAX_LEN    = hrhp_pkg::VALUE_MAX_LEN_DEF,
   parameter int LOCATION_MAX_LEN = hrhp_pkg::LOCATION_MAX_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_header_done,
   output logic [1:0]  rsp_outcome,
   output logic [9:0]  rsp_status_code,
   output logic [31:0] rsp_content_length,
   output logic        rsp_content_length_known,
   output logic [23:0] rsp_header_bytes,
   output logic [7:0]  rsp_location_byte,
   output logic        rsp_location_byte_valid,
   output logic        rsp_location_restart
);

   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           in_op_ff;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   hrhp_pkg::result_type result_ff, result_in;
   logic                 advance;
   logic                 accept;

   // the held item moves into the result register when that slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   hrhp_core #(
      .NAME_MAX_LEN     (NAME_MAX_LEN),
      .VALUE_MAX_LEN    (VALUE_MAX_LEN),
      .LOCATION_MAX_LEN (LOCATION_MAX_LEN)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .op      (in_op_ff),
      .byte_in (in_byte_ff),
      .result  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_byte_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_header_done          = result_ff.header_done;
   assign rsp_outcome              = result_ff.outcome;
   assign rsp_status_code          = result_ff.status_code;
   assign rsp_content_length       = result_ff.content_length;
   assign rsp_content_length_known = result_ff.content_length_known;
   assign rsp_header_bytes         = result_ff.header_bytes;
   assign rsp_location_byte        = result_ff.location_byte;
   assign rsp_location_byte_valid  = result_ff.location_byte_valid;
   assign rsp_location_restart     = result_ff.location_restart;

   `HRHP_ASSERT_NEXT(a_advance_fills_output, advance, rsp_valid_ff, "item lost between registers")
   `HRHP_ASSERT_IMPLY(a_done_has_outcome, rsp_valid_ff && rsp_header_done, rsp_outcome != hrhp_pkg::OUTCOME_PENDING, "header done without outcome")
   `HRHP_ASSERT_IMPLY(a_location_while_pending, rsp_valid_ff && (rsp_location_byte_valid || rsp_location_restart), rsp_outcome == hrhp_pkg::OUTCOME_PENDING && !rsp_header_done, "location item after header end")
   `HRHP_ASSERT_IMPLY(a_unknown_length_ones, rsp_valid_ff && !rsp_content_length_known, rsp_content_length == 32'hFFFF_FFFF, "unknown length not all ones")
   `HRHP_ASSERT_IMPLY(a_idle_location_zero, rsp_valid_ff && !rsp_location_byte_valid, rsp_location_byte == 8'h00, "location byte set without valid")

endmodule
